// File: sv/i2c_mbe_pkg.sv
// ----------------------------------------------------------------------------
// i2c_mbe_pkg
// Shared types and constants of the i2c master byte engine: phase codes,
// command codes and the result bundle passed from the core to the top level.
// ----------------------------------------------------------------------------
package i2c_mbe_pkg;

  localparam int unsigned ActionW    = 3;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned BitCountW  = 4;
  localparam int unsigned BitsPerByte = 8;

  localparam logic [ByteW-1:0] HalfPeriodReset = 8'd9;
  localparam logic [ByteW-1:0] MsbMask         = 8'h80;

  // command codes, 6 and 7 behave as idle ticks
  localparam logic [ActionW-1:0] ActIdle    = 3'd0;
  localparam logic [ActionW-1:0] ActStart   = 3'd1;
  localparam logic [ActionW-1:0] ActStop    = 3'd2;
  localparam logic [ActionW-1:0] ActWrite   = 3'd3;
  localparam logic [ActionW-1:0] ActReadAck = 3'd4;
  localparam logic [ActionW-1:0] ActReadNak = 3'd5;

  typedef enum logic [13:0] {
    PH_IDLE    = 14'b00000000000001,
    PH_ST_A    = 14'b00000000000010,
    PH_ST_B    = 14'b00000000000100,
    PH_SP_A    = 14'b00000000001000,
    PH_SP_B    = 14'b00000000010000,
    PH_SP_C    = 14'b00000000100000,
    PH_WR_LOW  = 14'b00000001000000,
    PH_WR_HIGH = 14'b00000010000000,
    PH_WA_LOW  = 14'b00000100000000,
    PH_WA_HIGH = 14'b00001000000000,
    PH_RD_LOW  = 14'b00010000000000,
    PH_RD_HIGH = 14'b00100000000000,
    PH_RA_LOW  = 14'b01000000000000,
    PH_RA_HIGH = 14'b10000000000000
  } phase_e;

  typedef struct packed {
    logic             scl_release;
    logic             sda_release;
    logic             busy;
    logic             done;
    logic [ByteW-1:0] rx_byte;
    logic             ack_seen;
    logic             cmd_dropped;
  } res_t;

endpackage

// File: sv/i2c_mbe_core.sv
// ----------------------------------------------------------------------------
// i2c_mbe_core
// Line state machine of the byte engine. Advances by one tick for every item
// stepped in and returns the line and status values after that tick.
// ----------------------------------------------------------------------------
module i2c_mbe_core
  import i2c_mbe_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [ActionW-1:0]   action_i,
  input  logic [ByteW-1:0]     tx_byte_i,
  input  logic                 sda_in_i,
  input  logic [ByteW-1:0]     half_period_i,
  output res_t                 res_o
);

  phase_e               phase_q, phase_d;
  logic [BitCountW-1:0] bit_count_q, bit_count_d;
  logic [ByteW-1:0]     shift_q, shift_d;
  logic [ByteW-1:0]     delay_q, delay_d;
  logic                 scl_q, scl_d;
  logic                 sda_q, sda_d;
  logic                 ack_flag_q, ack_flag_d;
  logic                 ack_send_q, ack_send_d;
  logic [ByteW-1:0]     rx_hold_q, rx_hold_d;

  logic [ByteW-1:0]     reload;
  logic [BitCountW-1:0] bit_count_inc;
  logic [ByteW-1:0]     shift_wr;
  logic [ByteW-1:0]     shift_rd;
  logic                 byte_end;
  logic                 is_cmd;
  logic                 done;

  // half_period of zero wraps to a 256-tick phase
  assign reload        = half_period_i - 8'd1;
  assign bit_count_inc = bit_count_q + 4'd1;
  assign byte_end      = (bit_count_inc >= BitCountW'(BitsPerByte));
  assign shift_wr      = {shift_q[ByteW-2:0], 1'b0};
  assign shift_rd      = {shift_q[ByteW-2:0], sda_in_i};
  assign is_cmd        = (action_i >= ActStart) && (action_i <= ActReadNak);

  always_comb begin
    phase_d     = phase_q;
    bit_count_d = bit_count_q;
    shift_d     = shift_q;
    delay_d     = delay_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    ack_flag_d  = ack_flag_q;
    ack_send_d  = ack_send_q;
    rx_hold_d   = rx_hold_q;
    done        = 1'b0;

    if (phase_q != PH_IDLE) begin
      if (delay_q != '0) begin
        delay_d = delay_q - 8'd1;
      end else begin
        delay_d = reload;
        case (phase_q)
          PH_ST_A: begin
            sda_d   = 1'b0;
            phase_d = PH_ST_B;
          end
          PH_ST_B: begin
            scl_d   = 1'b0;
            phase_d = PH_IDLE;
            delay_d = delay_q;
            done    = 1'b1;
          end
          PH_SP_A: begin
            scl_d   = 1'b1;
            phase_d = PH_SP_B;
          end
          PH_SP_B: begin
            sda_d   = 1'b1;
            phase_d = PH_SP_C;
          end
          PH_SP_C: begin
            phase_d = PH_IDLE;
            delay_d = delay_q;
            done    = 1'b1;
          end
          PH_WR_LOW: begin
            scl_d   = 1'b1;
            phase_d = PH_WR_HIGH;
          end
          PH_WR_HIGH: begin
            scl_d       = 1'b0;
            shift_d     = shift_wr;
            bit_count_d = bit_count_inc;
            if (byte_end) begin
              sda_d   = 1'b1;
              phase_d = PH_WA_LOW;
            end else begin
              sda_d   = |(shift_wr & MsbMask);
              phase_d = PH_WR_LOW;
            end
          end
          PH_WA_LOW: begin
            scl_d   = 1'b1;
            phase_d = PH_WA_HIGH;
          end
          PH_WA_HIGH: begin
            ack_flag_d = ~sda_in_i;
            scl_d      = 1'b0;
            phase_d    = PH_IDLE;
            delay_d    = delay_q;
            done       = 1'b1;
          end
          PH_RD_LOW: begin
            scl_d   = 1'b1;
            phase_d = PH_RD_HIGH;
          end
          PH_RD_HIGH: begin
            shift_d     = shift_rd;
            bit_count_d = bit_count_inc;
            scl_d       = 1'b0;
            if (byte_end) begin
              rx_hold_d = shift_rd;
              sda_d     = ack_send_q;
              phase_d   = PH_RA_LOW;
            end else begin
              phase_d   = PH_RD_LOW;
            end
          end
          PH_RA_LOW: begin
            scl_d   = 1'b1;
            phase_d = PH_RA_HIGH;
          end
          PH_RA_HIGH: begin
            scl_d   = 1'b0;
            sda_d   = 1'b1;
            phase_d = PH_IDLE;
            delay_d = delay_q;
            done    = 1'b1;
          end
          default: begin
            phase_d = PH_IDLE;
            delay_d = delay_q;
          end
        endcase
      end
    end else begin
      case (action_i)
        ActStart: begin
          sda_d   = 1'b1;
          scl_d   = 1'b1;
          phase_d = PH_ST_A;
          delay_d = reload;
        end
        ActStop: begin
          scl_d   = 1'b0;
          sda_d   = 1'b0;
          phase_d = PH_SP_A;
          delay_d = reload;
        end
        ActWrite: begin
          shift_d     = tx_byte_i;
          bit_count_d = '0;
          scl_d       = 1'b0;
          sda_d       = |(tx_byte_i & MsbMask);
          phase_d     = PH_WR_LOW;
          delay_d     = reload;
        end
        ActReadAck, ActReadNak: begin
          shift_d     = '0;
          bit_count_d = '0;
          ack_send_d  = (action_i == ActReadNak);
          scl_d       = 1'b0;
          sda_d       = 1'b1;
          phase_d     = PH_RD_LOW;
          delay_d     = reload;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bit_count_q <= '0;
      shift_q     <= '0;
      delay_q     <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      ack_flag_q  <= 1'b0;
      ack_send_q  <= 1'b1;
      rx_hold_q   <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      bit_count_q <= bit_count_d;
      shift_q     <= shift_d;
      delay_q     <= delay_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      ack_flag_q  <= ack_flag_d;
      ack_send_q  <= ack_send_d;
      rx_hold_q   <= rx_hold_d;
    end
  end

  assign res_o.scl_release = scl_d;
  assign res_o.sda_release = sda_d;
  assign res_o.busy        = (phase_d != PH_IDLE);
  assign res_o.done        = done;
  assign res_o.rx_byte     = rx_hold_d;
  assign res_o.ack_seen    = ack_flag_d;
  assign res_o.cmd_dropped = (phase_q != PH_IDLE) && is_cmd;

`ifndef ASSERT_OFF
  a_bit_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_count_q <= 4'd8)
    else $error("bit counter ran past a byte");

  a_idle_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (phase_q == PH_IDLE) && !is_cmd |=> (phase_q == PH_IDLE))
    else $error("engine left idle without a command");

  a_scl_low_in_data_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_WR_LOW) || (phase_q == PH_RD_LOW) |-> !scl_q)
    else $error("scl released during a low half phase");
`endif

endmodule

// File: sv/i2c_master_byte_engine_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_unit
// Usage: every input item is one tick of the i2c line engine. It carries a
// command code (idle, start, stop, write, read with ack, read with nack),
// the byte to send and the sampled SDA level. Each item yields exactly one
// result item with the open-drain SCL/SDA releases, busy, a done pulse, the
// last received byte, the last write ack and a dropped-command flag.
// Both channels use valid/ready. An item is registered on acceptance; when it
// is stepped its result is computed and captured in the output register. One
// item per cycle is sustained while the receiver does not stall; the only
// loop is the engine state, updated once per item.
// cfg_we_i writes half_period (ticks per SCL half phase), used by the next
// command; write it only while no item is in flight.
// Reset clears the engine to idle with both lines released, half_period 9.
// When the receiver stalls the result holds and, once the input register is
// also full, in_ready_o drops; no item is lost or repeated.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_unit
  import i2c_mbe_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ActionW-1:0] action_i,
  input  logic [ByteW-1:0]   tx_byte_i,
  input  logic               sda_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               scl_release_o,
  output logic               sda_release_o,
  output logic               busy_res_o,
  output logic               done_res_o,
  output logic [ByteW-1:0]   rx_byte_o,
  output logic               ack_seen_o,
  output logic               cmd_dropped_o,
  input  logic               cfg_we_i,
  input  logic [ByteW-1:0]   cfg_wdata_i
);

  logic               s1_valid_q, s1_valid_d;
  logic [ActionW-1:0] s1_action_q;
  logic [ByteW-1:0]   s1_tx_q;
  logic               s1_sda_q;
  logic               out_valid_q, out_valid_d;
  res_t               out_q;
  res_t               core_res;
  logic [ByteW-1:0]   half_period_q;
  logic               step;
  logic               in_fire;

  assign step        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || step;
  assign in_fire     = in_valid_i && in_ready_o;
  assign s1_valid_d  = in_fire || (s1_valid_q && !step);
  assign out_valid_d = step || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      half_period_q <= HalfPeriodReset;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        half_period_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_action_q <= action_i;
      s1_tx_q     <= tx_byte_i;
      s1_sda_q    <= sda_in_i;
    end
    if (step) begin
      out_q <= core_res;
    end
  end

  i2c_mbe_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .action_i      (s1_action_q),
    .tx_byte_i     (s1_tx_q),
    .sda_in_i      (s1_sda_q),
    .half_period_i (half_period_q),
    .res_o         (core_res)
  );

  assign out_valid_o   = out_valid_q;
  assign scl_release_o = out_q.scl_release;
  assign sda_release_o = out_q.sda_release;
  assign busy_res_o    = out_q.busy;
  assign done_res_o    = out_q.done;
  assign rx_byte_o     = out_q.rx_byte;
  assign ack_seen_o    = out_q.ack_seen;
  assign cmd_dropped_o = out_q.cmd_dropped;

`ifndef ASSERT_OFF
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.done && out_q.busy))
    else $error("done reported while still busy");

  a_stall_keeps_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |=> s1_valid_q)
    else $error("pending item lost during output stall");

  a_step_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("stepped item produced no result");
`endif

endmodule

// File: test/i2c_mbe_line_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_mbe_line_checker
// Watches both handshakes of the i2c master byte engine. Every accepted item
// is run through a cycle model of the line engine (phases, bit counter, shift
// register, hold counter, line levels, ack flags) and the predicted result
// is queued. Every accepted result item is compared field by field against
// the oldest prediction. Register writes are tracked so the model uses the
// same half period as the block.
// ----------------------------------------------------------------------------
module i2c_mbe_line_checker
  import i2c_mbe_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [ActionW-1:0] action_i,
  input  logic [ByteW-1:0]   tx_byte_i,
  input  logic               sda_in_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               scl_release_i,
  input  logic               sda_release_i,
  input  logic               busy_res_i,
  input  logic               done_res_i,
  input  logic [ByteW-1:0]   rx_byte_i,
  input  logic               ack_seen_i,
  input  logic               cmd_dropped_i,
  input  logic               cfg_we_i,
  input  logic [ByteW-1:0]   cfg_wdata_i,
  output int                 pending_o,
  output int                 fail_count_o
);

  localparam int ReportLimit = 10;

  logic [ByteW-1:0]     half_period_q;
  phase_e               phase_q;
  logic [BitCountW-1:0] bit_cnt_q;
  logic [ByteW-1:0]     shift_q;
  logic [ByteW-1:0]     hold_q;
  logic [ByteW-1:0]     rx_hold_q;
  logic                 scl_q;
  logic                 sda_q;
  logic                 ack_seen_q;
  logic                 ack_out_q;
  res_t                 line_q[$];
  int                   results_seen;

  function automatic void enter_phase(input phase_e nxt);
    phase_q = nxt;
    hold_q  = half_period_q - 8'd1;
  endfunction

  // one tick of the line engine, returns the levels and flags after the tick
  function automatic res_t engine_tick(input logic [ActionW-1:0] act,
                                       input logic [ByteW-1:0] tx,
                                       input logic sda);
    res_t r;
    logic fin;
    logic drop;
    fin  = 1'b0;
    drop = 1'b0;
    if (phase_q != PH_IDLE) begin
      drop = (act >= ActStart) && (act <= ActReadNak);
      if (hold_q != '0) begin
        hold_q = hold_q - 8'd1;
      end else begin
        case (phase_q)
          PH_ST_A: begin
            sda_q = 1'b0;
            enter_phase(PH_ST_B);
          end
          PH_ST_B: begin
            scl_q   = 1'b0;
            phase_q = PH_IDLE;
            fin     = 1'b1;
          end
          PH_SP_A: begin
            scl_q = 1'b1;
            enter_phase(PH_SP_B);
          end
          PH_SP_B: begin
            sda_q = 1'b1;
            enter_phase(PH_SP_C);
          end
          PH_SP_C: begin
            phase_q = PH_IDLE;
            fin     = 1'b1;
          end
          PH_WR_LOW: begin
            scl_q = 1'b1;
            enter_phase(PH_WR_HIGH);
          end
          PH_WR_HIGH: begin
            scl_q     = 1'b0;
            shift_q   = shift_q << 1;
            bit_cnt_q = bit_cnt_q + 1'b1;
            if (bit_cnt_q >= BitCountW'(BitsPerByte)) begin
              sda_q = 1'b1;
              enter_phase(PH_WA_LOW);
            end else begin
              sda_q = (shift_q & MsbMask) != '0;
              enter_phase(PH_WR_LOW);
            end
          end
          PH_WA_LOW: begin
            scl_q = 1'b1;
            enter_phase(PH_WA_HIGH);
          end
          PH_WA_HIGH: begin
            ack_seen_q = !sda;
            scl_q      = 1'b0;
            phase_q    = PH_IDLE;
            fin        = 1'b1;
          end
          PH_RD_LOW: begin
            scl_q = 1'b1;
            enter_phase(PH_RD_HIGH);
          end
          PH_RD_HIGH: begin
            shift_q   = {shift_q[ByteW-2:0], sda};
            bit_cnt_q = bit_cnt_q + 1'b1;
            scl_q     = 1'b0;
            if (bit_cnt_q >= BitCountW'(BitsPerByte)) begin
              rx_hold_q = shift_q;
              sda_q     = ack_out_q;
              enter_phase(PH_RA_LOW);
            end else begin
              enter_phase(PH_RD_LOW);
            end
          end
          PH_RA_LOW: begin
            scl_q = 1'b1;
            enter_phase(PH_RA_HIGH);
          end
          PH_RA_HIGH: begin
            scl_q   = 1'b0;
            sda_q   = 1'b1;
            phase_q = PH_IDLE;
            fin     = 1'b1;
          end
          default: phase_q = PH_IDLE;
        endcase
      end
    end else begin
      case (act)
        ActStart: begin
          sda_q = 1'b1;
          scl_q = 1'b1;
          enter_phase(PH_ST_A);
        end
        ActStop: begin
          scl_q = 1'b0;
          sda_q = 1'b0;
          enter_phase(PH_SP_A);
        end
        ActWrite: begin
          shift_q   = tx;
          bit_cnt_q = '0;
          scl_q     = 1'b0;
          sda_q     = (tx & MsbMask) != '0;
          enter_phase(PH_WR_LOW);
        end
        ActReadAck, ActReadNak: begin
          shift_q   = '0;
          bit_cnt_q = '0;
          ack_out_q = (act == ActReadNak);
          scl_q     = 1'b0;
          sda_q     = 1'b1;
          enter_phase(PH_RD_LOW);
        end
        default: ;
      endcase
    end
    r.scl_release = scl_q;
    r.sda_release = sda_q;
    r.busy        = (phase_q != PH_IDLE);
    r.done        = fin;
    r.rx_byte     = rx_hold_q;
    r.ack_seen    = ack_seen_q;
    r.cmd_dropped = drop;
    return r;
  endfunction

  task automatic flag_result(input string what, input res_t want, input res_t got);
    if (fail_count_o < ReportLimit) begin
      $display("%0t result %0d %s: expected scl %b sda %b busy %b done %b rx %h ack %b drop %b",
               $time, results_seen, what, want.scl_release, want.sda_release, want.busy,
               want.done, want.rx_byte, want.ack_seen, want.cmd_dropped);
      $display("%0t result %0d %s:   actual scl %b sda %b busy %b done %b rx %h ack %b drop %b",
               $time, results_seen, what, got.scl_release, got.sda_release, got.busy,
               got.done, got.rx_byte, got.ack_seen, got.cmd_dropped);
    end
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      half_period_q = HalfPeriodReset;
      phase_q       = PH_IDLE;
      bit_cnt_q     = '0;
      shift_q       = '0;
      hold_q        = '0;
      rx_hold_q     = '0;
      scl_q         = 1'b1;
      sda_q         = 1'b1;
      ack_seen_q    = 1'b0;
      ack_out_q     = 1'b1;
      results_seen  = 0;
      fail_count_o  = 0;
      line_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        half_period_q = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_i) begin
        line_q.push_back(engine_tick(action_i, tx_byte_i, sda_in_i));
      end
      if (out_valid_i && out_ready_i) begin
        got = {scl_release_i, sda_release_i, busy_res_i, done_res_i,
               rx_byte_i, ack_seen_i, cmd_dropped_i};
        if (line_q.size() == 0) begin
          flag_result("with nothing expected", '0, got);
        end else begin
          want = line_q.pop_front();
          if (got !== want) begin
            flag_result("mismatch", want, got);
          end
        end
        results_seen++;
      end
      pending_o <= line_q.size();
    end
  end

endmodule

// File: test/tb_i2c_master_byte_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_byte_engine_unit
// Drives line ticks into the i2c master byte engine: directed commands at the
// reset half period, at the shortest and at the longest half period, then
// random start / byte / stop transfers mixed with stray commands, under
// several half periods, with random gaps on the input and stalls on the
// output. The line checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_i2c_master_byte_engine_unit
  import i2c_mbe_pkg::*;
();

  localparam int TotalItems = 1950;
  localparam int SettleCycles = 10;
  localparam int SdaRandom = -1;
  localparam logic [ActionW-1:0] ActSpareLo = 3'd6;
  localparam logic [ActionW-1:0] ActSpareHi = 3'd7;
  localparam logic [ByteW-1:0] HalfPeriodMin = 8'd1;
  localparam logic [ByteW-1:0] HalfPeriodMax = 8'd255;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [ActionW-1:0] action_i = ActIdle;
  logic [ByteW-1:0]   tx_byte_i = '0;
  logic               sda_in_i = 1'b1;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               scl_release_o;
  logic               sda_release_o;
  logic               busy_res_o;
  logic               done_res_o;
  logic [ByteW-1:0]   rx_byte_o;
  logic               ack_seen_o;
  logic               cmd_dropped_o;
  logic               cfg_we_i = 1'b0;
  logic [ByteW-1:0]   cfg_wdata_i = '0;

  int               pending;
  int               fail_count;
  int               items_sent = 0;
  bit               calm = 1'b0;
  logic [ByteW-1:0] hp_now = HalfPeriodReset;

  i2c_master_byte_engine_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .tx_byte_i     (tx_byte_i),
    .sda_in_i      (sda_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .scl_release_o (scl_release_o),
    .sda_release_o (sda_release_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .rx_byte_o     (rx_byte_o),
    .ack_seen_o    (ack_seen_o),
    .cmd_dropped_o (cmd_dropped_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  i2c_mbe_line_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .action_i      (action_i),
    .tx_byte_i     (tx_byte_i),
    .sda_in_i      (sda_in_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .scl_release_i (scl_release_o),
    .sda_release_i (sda_release_o),
    .busy_res_i    (busy_res_o),
    .done_res_i    (done_res_o),
    .rx_byte_i     (rx_byte_o),
    .ack_seen_i    (ack_seen_o),
    .cmd_dropped_i (cmd_dropped_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pending_o     (pending),
    .fail_count_o  (fail_count)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 10);
  end

  task automatic send_item(input logic [ActionW-1:0] act, input logic [ByteW-1:0] tx,
                           input logic sda);
    if (!calm) begin
      while ($urandom_range(0, 99) < 10) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    tx_byte_i  <= tx;
    sda_in_i   <= sda;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  // hold the input until every result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_half_period(input logic [ByteW-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hp_now = value;
  endtask

  // issue one command and keep ticking until it has completed
  task automatic run_cmd(input logic [ActionW-1:0] act, input logic [ByteW-1:0] tx,
                         input int sda_fix);
    int               ticks;
    logic [ActionW-1:0] filler;
    logic             sda;
    case (act)
      ActStart:                         ticks = 2;
      ActStop:                          ticks = 3;
      ActWrite, ActReadAck, ActReadNak: ticks = 18;
      default:                          ticks = 0;
    endcase
    ticks = ticks * int'(hp_now);
    sda = (sda_fix < 0) ? 1'($urandom_range(0, 1)) : sda_fix[0];
    send_item(act, tx, sda);
    repeat (ticks) begin
      case ($urandom_range(0, 19))
        0:       filler = ActionW'($urandom_range(ActStart, ActReadNak));  // dropped while busy
        1:       filler = ActionW'($urandom_range(ActSpareLo, ActSpareHi));
        default: filler = ActIdle;
      endcase
      sda = (sda_fix < 0) ? 1'($urandom_range(0, 1)) : sda_fix[0];
      send_item(filler, ByteW'($urandom_range(0, 255)), sda);
    end
    // engine is idle here, so only harmless codes
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        filler = ($urandom_range(0, 1) == 0) ? ActIdle
                                             : ActionW'($urandom_range(ActSpareLo, ActSpareHi));
        send_item(filler, ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic run_transfer();
    run_cmd(ActStart, ByteW'($urandom_range(0, 255)), SdaRandom);
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 2))
        0:       run_cmd(ActWrite, ByteW'($urandom_range(0, 255)), SdaRandom);
        1:       run_cmd(ActReadAck, ByteW'($urandom_range(0, 255)), SdaRandom);
        default: run_cmd(ActReadNak, ByteW'($urandom_range(0, 255)), SdaRandom);
      endcase
    end
    run_cmd(ActStop, ByteW'($urandom_range(0, 255)), SdaRandom);
  endtask

  initial begin
    int               round;
    logic [ByteW-1:0] hp_pick;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset half period, all-ones byte with no ack
    run_cmd(ActStart, 8'h00, SdaRandom);
    run_cmd(ActWrite, 8'hFF, 1);
    run_cmd(ActStop, 8'h00, SdaRandom);

    set_half_period(HalfPeriodMin);
    run_cmd(ActWrite, 8'h00, 0);
    run_cmd(ActReadAck, 8'hFF, 1);
    run_cmd(ActReadNak, 8'h00, 0);
    run_cmd(ActSpareLo, 8'hFF, 1);
    run_cmd(ActSpareHi, 8'h00, 0);
    run_cmd(ActIdle, 8'hA5, 1);
    // command while busy, then one on the completing tick
    send_item(ActStart, 8'h00, 1'b1);
    send_item(ActStop, 8'h00, 1'b1);
    send_item(ActWrite, 8'h5A, 1'b0);
    send_item(ActIdle, 8'h00, 1'b0);
    run_cmd(ActStop, 8'h00, SdaRandom);

    set_half_period(HalfPeriodMax);
    run_cmd(ActStart, 8'h00, SdaRandom);

    round = 0;
    while (items_sent < TotalItems) begin
      case ($urandom_range(0, 7))
        0, 1, 2, 3: hp_pick = 8'd1;
        4, 5:       hp_pick = 8'd2;
        6:          hp_pick = 8'd3;
        default:    hp_pick = ByteW'($urandom_range(4, 7));
      endcase
      set_half_period(hp_pick);
      calm = (round == 0);
      repeat ($urandom_range(2, 4)) begin
        if ($urandom_range(0, 4) == 0) begin
          run_cmd(ActionW'($urandom_range(0, 7)), ByteW'($urandom_range(0, 255)), SdaRandom);
        end else begin
          run_transfer();
        end
        if ($urandom_range(0, 9) == 0) begin
          drain();
        end
      end
      round++;
    end
    calm = 1'b0;

    drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
